// File: rtl/ping_frame_builder_crc16_assert.svh
// assertion macros used by the checker file pfb_checker.sv
`ifndef PING_FRAME_BUILDER_CRC16_ASSERT_SVH
`define PING_FRAME_BUILDER_CRC16_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define PFB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define PFB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/pfb_pkg.sv
package pfb_pkg;

  typedef struct packed {
    logic [15:0] sequence_number;
    logic [31:0] ping_nonce;
  } ping_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } tx_t;

  typedef struct packed {
    ping_t       item;
    logic [15:0] crc;
  } stage_t;

  typedef enum logic [7:0] {
    REG_START_FIRST  = 8'd0,
    REG_START_SECOND = 8'd1,
    REG_VERSION      = 8'd2,
    REG_TYPE         = 8'd3
  } cfg_reg_t;

  localparam int          FRAME_LEN   = 14;
  localparam int          CRC_STAGES  = 5;
  localparam logic [3:0]  LAST_IDX    = 4'(FRAME_LEN - 1);
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'hA001;
  localparam logic [15:0] PAYLOAD_LEN = 16'd4;

  // reflected crc of one byte from zero, acts as a 256 entry table
  function automatic logic [15:0] crc_tab(input logic [7:0] idx);
    logic [15:0] c;
    c = {8'h00, idx};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    return {8'h00, crc[15:8]} ^ crc_tab(crc[7:0] ^ b);
  endfunction

endpackage

// File: rtl/pfb_crc_stage.sv
module pfb_crc_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            up_valid,
  output logic            up_stall,
  input  pfb_pkg::stage_t up,
  input  logic [7:0]      byte_first,
  input  logic [7:0]      byte_second,
  output logic            dn_valid,
  input  logic            dn_stall,
  output pfb_pkg::stage_t dn
);
  import pfb_pkg::*;

  logic        valid;
  stage_t      data;
  logic [15:0] crc_mid;
  stage_t      data_next;

  assign up_stall = valid && dn_stall;
  assign dn_valid = valid;
  assign dn       = data;

  always_comb begin
    crc_mid        = crc_byte(up.crc, byte_first);
    data_next.item = up.item;
    data_next.crc  = crc_byte(crc_mid, byte_second);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!up_stall) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!up_stall && up_valid) begin
      data <= data_next;
    end
  end

endmodule

// File: rtl/ping_frame_builder_crc16.sv
// channel | dir | handshake             | beat
// ping    | in  | ping_valid/ping_stall | sequence number and nonce
// tx      | out | tx_valid/tx_stall     | one frame byte, end flag on the last
// cfg     | in  | cfg_valid/cfg_ready   | register index and write data
//
// each ping beat gives 14 tx beats, one per cycle while tx is not stalled
// the byte serializer sets the rate: it loads the next frame as the last byte of the current one is taken
// the first byte passes through the 5 crc stages and the serializer register before it appears
// synchronous rst clears valid bits, cfg registers and serializer state, cfg_ready is always high
// stalls on tx back up through the crc stages without losing a beat
module ping_frame_builder_crc16 (
  input  logic           clk,
  input  logic           rst,
  input  logic           ping_valid,
  output logic           ping_stall,
  input  pfb_pkg::ping_t ping,
  output logic           tx_valid,
  input  logic           tx_stall,
  output pfb_pkg::tx_t   tx,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [7:0]     cfg_index,
  input  logic [7:0]     cfg_data
);
  import pfb_pkg::*;

  logic [7:0] start_first;
  logic [7:0] start_second;
  logic [7:0] version;
  logic [7:0] type_code;

  logic [CRC_STAGES:0] sv;
  logic [CRC_STAGES:0] sst;
  stage_t              sd [CRC_STAGES+1];
  logic [7:0]          b_first  [CRC_STAGES];
  logic [7:0]          b_second [CRC_STAGES];

  logic        busy;
  logic [3:0]  idx;
  ping_t       fr_item;
  logic [15:0] fr_crc;
  logic        tx_take;
  logic        ser_load;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_first  <= 8'h00;
      start_second <= 8'h00;
      version      <= 8'h00;
      type_code    <= 8'h00;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_START_FIRST:  start_first  <= cfg_data;
        REG_START_SECOND: start_second <= cfg_data;
        REG_VERSION:      version      <= cfg_data;
        REG_TYPE:         type_code    <= cfg_data;
        default:          ;
      endcase
    end
  end

  assign sv[0]      = ping_valid;
  assign sd[0]      = '{item: ping, crc: CRC_INIT};
  assign ping_stall = sst[0];

  // two crc bytes per stage
  always_comb begin
    b_first[0]  = version;
    b_second[0] = type_code;
    b_first[1]  = sd[1].item.sequence_number[7:0];
    b_second[1] = sd[1].item.sequence_number[15:8];
    b_first[2]  = PAYLOAD_LEN[7:0];
    b_second[2] = PAYLOAD_LEN[15:8];
    b_first[3]  = sd[3].item.ping_nonce[7:0];
    b_second[3] = sd[3].item.ping_nonce[15:8];
    b_first[4]  = sd[4].item.ping_nonce[23:16];
    b_second[4] = sd[4].item.ping_nonce[31:24];
  end

  for (genvar g = 0; g < CRC_STAGES; g++) begin : g_stage
    pfb_crc_stage u_stage (
      .clk         (clk),
      .rst         (rst),
      .up_valid    (sv[g]),
      .up_stall    (sst[g]),
      .up          (sd[g]),
      .byte_first  (b_first[g]),
      .byte_second (b_second[g]),
      .dn_valid    (sv[g+1]),
      .dn_stall    (sst[g+1]),
      .dn          (sd[g+1])
    );
  end

  // byte serializer
  assign tx_take  = busy && !tx_stall;
  assign ser_load = !busy || (tx_take && (idx == LAST_IDX));
  assign sst[CRC_STAGES] = !ser_load;
  assign tx_valid = busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 4'd0;
    end else if (ser_load) begin
      busy <= sv[CRC_STAGES];
      idx  <= 4'd0;
    end else if (tx_take) begin
      idx <= idx + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ser_load && sv[CRC_STAGES]) begin
      fr_item <= sd[CRC_STAGES].item;
      fr_crc  <= sd[CRC_STAGES].crc;
    end
  end

  always_comb begin
    tx.frame_end = (idx == LAST_IDX);
    unique case (idx)
      4'd0:    tx.frame_byte = start_first;
      4'd1:    tx.frame_byte = start_second;
      4'd2:    tx.frame_byte = version;
      4'd3:    tx.frame_byte = type_code;
      4'd4:    tx.frame_byte = fr_item.sequence_number[7:0];
      4'd5:    tx.frame_byte = fr_item.sequence_number[15:8];
      4'd6:    tx.frame_byte = PAYLOAD_LEN[7:0];
      4'd7:    tx.frame_byte = PAYLOAD_LEN[15:8];
      4'd8:    tx.frame_byte = fr_item.ping_nonce[7:0];
      4'd9:    tx.frame_byte = fr_item.ping_nonce[15:8];
      4'd10:   tx.frame_byte = fr_item.ping_nonce[23:16];
      4'd11:   tx.frame_byte = fr_item.ping_nonce[31:24];
      4'd12:   tx.frame_byte = fr_crc[7:0];
      default: tx.frame_byte = fr_crc[15:8];
    endcase
  end

endmodule

// File: rtl/pfb_checker.sv
`include "ping_frame_builder_crc16_assert.svh"

module pfb_checker (
  input logic         clk,
  input logic         rst,
  input logic         tx_valid,
  input logic         tx_stall,
  input pfb_pkg::tx_t tx
);
  import pfb_pkg::*;

  logic [3:0] beat_cnt;
  logic       take;

  assign take = tx_valid && !tx_stall;

  // beats seen in the current frame
  always_ff @(posedge clk) begin
    if (rst) begin
      beat_cnt <= 4'd0;
    end else if (take) begin
      beat_cnt <= tx.frame_end ? 4'd0 : beat_cnt + 4'd1;
    end
  end

  `PFB_ASSERT_NXT(a_frame_gapless, take && !tx.frame_end, tx_valid, "gap inside a frame")
  `PFB_ASSERT_NXT(a_tx_hold, tx_valid && tx_stall, tx_valid && $stable(tx), "stalled beat changed")
  `PFB_ASSERT_IMP(a_end_pos, take, tx.frame_end == (beat_cnt == LAST_IDX), "frame end misplaced")

endmodule

bind ping_frame_builder_crc16 pfb_checker u_pfb_checker (
  .clk      (clk),
  .rst      (rst),
  .tx_valid (tx_valid),
  .tx_stall (tx_stall),
  .tx       (tx)
);
